### src/pdm2_pkg.sv
// Shared package for the second-order PDM modulator.
// Holds the fixed field widths, loop constants and the controller command struct.
// No dependencies.
`default_nettype none
package pdm2_pkg;

   localparam int WORDS_PER_SAMPLE = 8;
   localparam int BITS_PER_WORD    = 32;

   localparam int SAMPLE_W     = 32;
   localparam int THRESH_W     = 15;
   localparam int TARGET_W     = 16;
   localparam int INTEG_W      = 32;
   localparam int OUT_WORD_W   = 32;
   localparam int SHIFT_AMOUNT = 14;
   localparam int CLIP_W       = SAMPLE_W - SHIFT_AMOUNT;

   localparam int TARGET_OFFSET = 32768;
   localparam logic [INTEG_W-1:0]  FEEDBACK_HIGH = 32'd65535;
   localparam logic [THRESH_W-1:0] THRESH_RESET  = 15'd26214;

   typedef struct packed {
      logic load;
      logic step;
      logic emit;
      logic last;
   } cmd_type;

endpackage
`default_nettype wire

### src/pdm2_ctrl.sv
// Controller for the second-order PDM modulator.
// Sequences bit steps and word emits, owns the response valid flag; uses pdm2_pkg.
`default_nettype none
module pdm2_ctrl #(
   parameter int WORDS_PER_SAMPLE = pdm2_pkg::WORDS_PER_SAMPLE,
   parameter int BITS_PER_WORD    = pdm2_pkg::BITS_PER_WORD
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output pdm2_pkg::cmd_type cmd
);

   localparam int BIT_CNT_W  = (BITS_PER_WORD > 1) ? $clog2(BITS_PER_WORD) : 1;
   localparam int WORD_CNT_W = (WORDS_PER_SAMPLE > 1) ? $clog2(WORDS_PER_SAMPLE) : 1;
   localparam logic [BIT_CNT_W-1:0]  LAST_BIT  = BIT_CNT_W'(BITS_PER_WORD - 1);
   localparam logic [WORD_CNT_W-1:0] LAST_WORD = WORD_CNT_W'(WORDS_PER_SAMPLE - 1);
   localparam logic [BIT_CNT_W-1:0]  BIT_ONE   = BIT_CNT_W'(1);
   localparam logic [WORD_CNT_W-1:0] WORD_ONE  = WORD_CNT_W'(1);

   typedef enum logic {IDLE, RUN} state_type;

   state_type             state_ff, state_in;
   logic [BIT_CNT_W-1:0]  bit_cnt_ff, bit_cnt_in;
   logic [WORD_CNT_W-1:0] word_cnt_ff, word_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  out_free;
   logic                  word_end;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign word_end  = (bit_cnt_ff == LAST_BIT);
   assign req_stall = (state_ff == RUN);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      bit_cnt_in   = bit_cnt_ff;
      word_cnt_in  = word_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load    = 1'b1;
               bit_cnt_in  = '0;
               word_cnt_in = '0;
               state_in    = RUN;
            end
         end
         RUN: begin
            if (!word_end || out_free) begin
               cmd.step   = 1'b1;
               bit_cnt_in = bit_cnt_ff + BIT_ONE;
               if (word_end) begin
                  cmd.emit     = 1'b1;
                  cmd.last     = (word_cnt_ff == LAST_WORD);
                  rsp_valid_in = 1'b1;
                  bit_cnt_in   = '0;
                  word_cnt_in  = word_cnt_ff + WORD_ONE;
                  if (word_cnt_ff == LAST_WORD) begin
                     state_in = IDLE;
                  end
               end
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         bit_cnt_ff   <= '0;
         word_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bit_cnt_ff   <= bit_cnt_in;
         word_cnt_ff  <= word_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

### src/pdm2_datapath.sv
// Datapath for the second-order PDM modulator: clip threshold, target,
// integrators, bit shift register and output word register; uses pdm2_pkg.
`default_nettype none
module pdm2_datapath #(
   parameter int BITS_PER_WORD = pdm2_pkg::BITS_PER_WORD
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_wr_en,
   input  wire  [pdm2_pkg::THRESH_W-1:0]         csr_wr_data,
   input  wire  signed [pdm2_pkg::SAMPLE_W-1:0]  req_sample,
   input  wire                                   req_reset_state,
   input  pdm2_pkg::cmd_type                     cmd,
   output logic [pdm2_pkg::OUT_WORD_W-1:0]       rsp_bit_word,
   output logic                                  rsp_last_word
);

   localparam int IW = pdm2_pkg::INTEG_W;
   localparam int CW = pdm2_pkg::CLIP_W;

   logic [pdm2_pkg::THRESH_W-1:0]   clip_ff;
   logic [pdm2_pkg::TARGET_W-1:0]   target_ff, target_in;
   logic [IW-1:0]                   fi_ff, fi_in;
   logic [IW-1:0]                   si_ff, si_in;
   logic [BITS_PER_WORD-1:0]        shift_ff, word_next;
   logic [pdm2_pkg::OUT_WORD_W-1:0] pdm_ff;
   logic                            last_ff;
   logic signed [CW-1:0]            sh_val, lim, v, v_off;
   logic                            pdm_bit;
   logic [IW-1:0]                   fb;

   always_comb begin
      sh_val = signed'(req_sample[pdm2_pkg::SAMPLE_W-1:pdm2_pkg::SHIFT_AMOUNT]);
      lim    = signed'(CW'(clip_ff));
      v      = req_reset_state ? '0 : sh_val;
      if (v > lim) begin
         v = lim;
      end else if (v < -lim) begin
         v = -lim;
      end
      v_off     = v + signed'(CW'(pdm2_pkg::TARGET_OFFSET));
      target_in = v_off[pdm2_pkg::TARGET_W-1:0];
   end

   always_comb begin
      pdm_bit   = !si_ff[IW-1];
      fb        = pdm_bit ? pdm2_pkg::FEEDBACK_HIGH : '0;
      fi_in     = fi_ff + IW'(target_ff) - fb;
      si_in     = si_ff + fi_in - fb;
      word_next = {shift_ff[BITS_PER_WORD-2:0], pdm_bit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_ff <= pdm2_pkg::THRESH_RESET;
      end else if (csr_wr_en) begin
         clip_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fi_ff <= '0;
         si_ff <= '0;
      end else if (cmd.load) begin
         if (req_reset_state) begin
            fi_ff <= '0;
            si_ff <= '0;
         end
      end else if (cmd.step) begin
         fi_ff <= fi_in;
         si_ff <= si_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         target_ff <= target_in;
      end
      if (cmd.step) begin
         shift_ff <= word_next;
      end
      if (cmd.emit) begin
         pdm_ff  <= pdm2_pkg::OUT_WORD_W'(word_next);
         last_ff <= cmd.last;
      end
   end

   assign rsp_bit_word  = pdm_ff;
   assign rsp_last_word = last_ff;

endmodule
`default_nettype wire

### src/second_order_pdm_modulator_top.sv
// Top level of the second-order PDM modulator.
// Instantiates pdm2_ctrl and pdm2_datapath; uses pdm2_pkg.
`default_nettype none
// Each accepted sample is loaded and then run through WORDS_PER_SAMPLE *
// BITS_PER_WORD modulator bit steps through the two chained integrator
// adders, one bit step per cycle while no stalled word holds the loop. Words
// leave through a single output register; a stalled word holds the loop at
// the next word boundary. The next sample is taken as soon as the last bit
// step is done, while the last word may still wait in the output register.
module second_order_pdm_modulator_top #(
   parameter int WORDS_PER_SAMPLE = pdm2_pkg::WORDS_PER_SAMPLE,
   parameter int BITS_PER_WORD    = pdm2_pkg::BITS_PER_WORD
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_wr_en,
   input  wire  [pdm2_pkg::THRESH_W-1:0]        csr_wr_data,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire  signed [pdm2_pkg::SAMPLE_W-1:0] req_sample,
   input  wire                                  req_reset_state,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic [pdm2_pkg::OUT_WORD_W-1:0]      rsp_bit_word,
   output logic                                 rsp_last_word
);

   pdm2_pkg::cmd_type cmd;

   pdm2_ctrl #(
      .WORDS_PER_SAMPLE(WORDS_PER_SAMPLE),
      .BITS_PER_WORD   (BITS_PER_WORD)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .cmd      (cmd)
   );

   pdm2_datapath #(
      .BITS_PER_WORD(BITS_PER_WORD)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_sample     (req_sample),
      .req_reset_state(req_reset_state),
      .cmd            (cmd),
      .rsp_bit_word   (rsp_bit_word),
      .rsp_last_word  (rsp_last_word)
   );

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !(rsp_valid && rsp_stall))
      else $error("output word overwritten while stalled");

   a_load_xor_step: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.step))
      else $error("load and step in the same cycle");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid)
      else $error("emitted word not presented");

   a_emit_is_step: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit || cmd.last) |-> cmd.step && cmd.emit)
      else $error("emit without bit step");
`endif

endmodule
`default_nettype wire

### bench/second_order_pdm_modulator_top_tb.sv
// Self-checking bench for second_order_pdm_modulator_top: drives samples and
// threshold writes, predicts each transaction's eight PDM words and checks them.
// Depends on pdm2_pkg and the RTL under src/.
`timescale 1ns / 1ps
module second_order_pdm_modulator_top_tb;

   typedef struct packed {
      logic [pdm2_pkg::OUT_WORD_W-1:0] bit_word;
      logic                            last_word;
   } pdm_result_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [pdm2_pkg::THRESH_W-1:0] csr_wr_data;
   logic req_valid;
   logic req_stall;
   logic signed [pdm2_pkg::SAMPLE_W-1:0] req_sample;
   logic req_reset_state;
   logic rsp_valid;
   logic rsp_stall;
   logic [pdm2_pkg::OUT_WORD_W-1:0] rsp_bit_word;
   logic rsp_last_word;

   pdm_result_type pending_words[$];
   logic [pdm2_pkg::THRESH_W-1:0] clip_limit;
   logic [pdm2_pkg::INTEG_W-1:0] integ_one;
   logic [pdm2_pkg::INTEG_W-1:0] integ_two;
   int mismatches = 0;

   int gap_max = 0;
   int burst_left = 0;
   int stall_pct = 0;
   int stall_run = 0;
   logic stall_now = 1'b0;
   logic holding = 1'b0;
   logic signed [pdm2_pkg::SAMPLE_W-1:0] dc_level = '0;
   event hold_go;

   second_order_pdm_modulator_top dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sample(req_sample),
      .req_reset_state(req_reset_state),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_bit_word(rsp_bit_word),
      .rsp_last_word(rsp_last_word)
   );

   always #2 clock = ~clock;

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // receiver back-pressure: random runs, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_run == 0) begin
            stall_run = $urandom_range(1, 12);
            stall_now = ($urandom_range(0, 99) < stall_pct);
         end
         stall_run = stall_run - 1;
         rsp_stall <= holding | stall_now;
      end
   end

   always begin
      @(hold_go);
      holding <= 1'b1;
      repeat (900) @(posedge clock);
      holding <= 1'b0;
   end

   always @(posedge clock) begin
      pdm_result_type exp_word;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected word, expected none actual %h last %b",
                     $time, rsp_bit_word, rsp_last_word);
            mismatches++;
         end else begin
            exp_word = pending_words.pop_front();
            if (rsp_bit_word !== exp_word.bit_word) begin
               $display("%0t: bit_word mismatch expected %h actual %h",
                        $time, exp_word.bit_word, rsp_bit_word);
               mismatches++;
            end
            if (rsp_last_word !== exp_word.last_word) begin
               $display("%0t: last_word mismatch expected %b actual %b",
                        $time, exp_word.last_word, rsp_last_word);
               mismatches++;
            end
         end
      end
   end

   task automatic modulate_sample(input logic signed [pdm2_pkg::SAMPLE_W-1:0] s,
                                  input logic rs);
      logic signed [pdm2_pkg::INTEG_W-1:0] level;
      logic signed [pdm2_pkg::INTEG_W-1:0] lim;
      logic [pdm2_pkg::INTEG_W-1:0] target;
      logic [pdm2_pkg::INTEG_W-1:0] fb;
      logic [pdm2_pkg::BITS_PER_WORD-1:0] word;
      logic bit_on;
      pdm_result_type res;
      lim = {{(pdm2_pkg::INTEG_W-pdm2_pkg::THRESH_W){1'b0}}, clip_limit};
      if (rs) begin
         integ_one = '0;
         integ_two = '0;
         level = '0;
      end else begin
         level = s >>> pdm2_pkg::SHIFT_AMOUNT;
      end
      if (level > lim) level = lim;
      if (level < -lim) level = -lim;
      target = level + pdm2_pkg::TARGET_OFFSET;
      for (int w = 0; w < pdm2_pkg::WORDS_PER_SAMPLE; w++) begin
         word = '0;
         for (int k = 0; k < pdm2_pkg::BITS_PER_WORD; k++) begin
            bit_on = ~integ_two[pdm2_pkg::INTEG_W-1];
            fb = bit_on ? pdm2_pkg::FEEDBACK_HIGH : '0;
            word[pdm2_pkg::BITS_PER_WORD-1-k] = bit_on;
            integ_one = integ_one + target - fb;
            integ_two = integ_two + integ_one - fb;
         end
         res.bit_word = word[pdm2_pkg::OUT_WORD_W-1:0];
         res.last_word = (w == pdm2_pkg::WORDS_PER_SAMPLE - 1);
         pending_words.push_back(res);
      end
   endtask

   task automatic send_sample(input logic signed [pdm2_pkg::SAMPLE_W-1:0] s,
                              input logic rs);
      logic [31:0] rnd;
      req_valid <= 1'b1;
      req_sample <= s;
      req_reset_state <= rs;
      forever begin
         @(posedge clock);
         if (req_stall === 1'b0) break;
      end
      modulate_sample(s, rs);
      if (gap_max > 0) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 6);
            req_valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) begin
               rnd = $urandom;
               req_sample <= $urandom;
               req_reset_state <= rnd[0];
               @(posedge clock);
            end
         end else begin
            burst_left = burst_left - 1;
         end
      end
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_clip_threshold(input logic [pdm2_pkg::THRESH_W-1:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      clip_limit = v;
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic signed [pdm2_pkg::SAMPLE_W-1:0] pick_sample();
      logic [31:0] rnd;
      logic signed [15:0] hi;
      logic [pdm2_pkg::SHIFT_AMOUNT-1:0] lo;
      rnd = $urandom;
      hi = rnd[15:0];
      lo = rnd[16 +: pdm2_pkg::SHIFT_AMOUNT];
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return {{(pdm2_pkg::SAMPLE_W-16-pdm2_pkg::SHIFT_AMOUNT){hi[15]}}, hi, lo};
         2: begin
            dc_level = {{(pdm2_pkg::SAMPLE_W-16-pdm2_pkg::SHIFT_AMOUNT){hi[15]}}, hi, lo};
            return dc_level;
         end
         default: return dc_level;
      endcase
   endfunction

   task automatic test_default_threshold();
      gap_max = 0;
      stall_pct = 0;
      send_sample(32'sd0, 1'b1);
      send_sample(32'sh7FFF_FFFF, 1'b0);
      send_sample(32'sh8000_0000, 1'b0);
      send_sample(32'sd0, 1'b0);
      send_sample(-32'sd1, 1'b0);
      send_sample(32'sd1 <<< pdm2_pkg::SHIFT_AMOUNT, 1'b0);
      send_sample(32'sd26214 <<< pdm2_pkg::SHIFT_AMOUNT, 1'b0);
      send_sample(32'sd26215 <<< pdm2_pkg::SHIFT_AMOUNT, 1'b0);
      send_sample(-(32'sd26215 <<< pdm2_pkg::SHIFT_AMOUNT), 1'b0);
      wait_for_drain();
   endtask

   task automatic test_threshold_extremes();
      write_clip_threshold('0);
      send_sample(32'sh7FFF_FFFF, 1'b0);
      send_sample(32'sh8000_0000, 1'b0);
      send_sample(32'sh1234_5678, 1'b1);
      wait_for_drain();
      write_clip_threshold({pdm2_pkg::THRESH_W{1'b1}});
      send_sample(32'sh7FFF_FFFF, 1'b0);
      send_sample(32'sh7FFF_FFFF, 1'b0);
      send_sample(32'sh8000_0000, 1'b0);
      send_sample(32'sh8000_0000, 1'b0);
      send_sample(32'sd32767 <<< pdm2_pkg::SHIFT_AMOUNT, 1'b0);
      send_sample(-(32'sd32767 <<< pdm2_pkg::SHIFT_AMOUNT), 1'b0);
      send_sample(32'shFFFF_FFFF, 1'b1);
      wait_for_drain();
      write_clip_threshold(15'd1);
      send_sample(32'sh7FFF_FFFF, 1'b0);
      wait_for_drain();
   endtask

   task automatic test_backpressure_fill();
      gap_max = 0;
      stall_pct = 0;
      -> hold_go;
      repeat (4) send_sample(pick_sample(), 1'b0);
      wait_for_drain();
   endtask

   task automatic test_quiet_stream();
      gap_max = 0;
      stall_pct = 0;
      repeat (8) send_sample(pick_sample(), 1'b0);
      wait_for_drain();
   endtask

   task automatic test_random_traffic(input int count, input int thr);
      write_clip_threshold(thr[pdm2_pkg::THRESH_W-1:0]);
      gap_max = 300;
      burst_left = 0;
      stall_pct = $urandom_range(10, 60);
      repeat (count) send_sample(pick_sample(), $urandom_range(0, 99) < 6);
      wait_for_drain();
   endtask

   initial begin
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      req_valid <= 1'b0;
      req_sample <= '0;
      req_reset_state <= 1'b0;
      clip_limit = pdm2_pkg::THRESH_RESET;
      integ_one = '0;
      integ_two = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_threshold();
      test_threshold_extremes();
      test_backpressure_fill();
      test_quiet_stream();
      test_random_traffic(22, pdm2_pkg::THRESH_RESET);
      test_random_traffic(22, $urandom_range(1, 32766));
      test_random_traffic(22, {pdm2_pkg::THRESH_W{1'b1}});
      test_random_traffic(22, $urandom_range(0, 200));

      wait_for_drain();
      repeat (300) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### filelist.f
src/pdm2_pkg.sv
src/pdm2_ctrl.sv
src/pdm2_datapath.sv
src/second_order_pdm_modulator_top.sv
bench/second_order_pdm_modulator_top_tb.sv
